### rtl/biquad_iir_filter_core_defines.svh
`ifndef BIQUAD_IIR_FILTER_CORE_DEFINES_SVH
`define BIQUAD_IIR_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BQF_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, checked outside reset.
`define BQF_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

### rtl/bqf_pkg.sv
`timescale 1ns / 1ps

package bqf_pkg;

  localparam int COEF_WIDTH    = 16;
  localparam int COEF_FRAC     = 14;
  localparam int CFG_IDX_WIDTH = 3;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } cfg_reg_e;

  localparam logic signed [COEF_WIDTH-1:0] B0_RESET = 16'sd14991;
  localparam logic signed [COEF_WIDTH-1:0] B1_RESET = -16'sd29982;
  localparam logic signed [COEF_WIDTH-1:0] B2_RESET = 16'sd14991;
  localparam logic signed [COEF_WIDTH-1:0] A1_RESET = -16'sd29863;
  localparam logic signed [COEF_WIDTH-1:0] A2_RESET = 16'sd13716;

endpackage

### rtl/bqf_serial_mult.sv
`timescale 1ns / 1ps
`include "biquad_iir_filter_core_defines.svh"

module bqf_serial_mult
  import bqf_pkg::*;
#(
  parameter int DATA_WIDTH = 24
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       start_i,
  input  logic signed [COEF_WIDTH-1:0]               coef_i,
  input  logic signed [DATA_WIDTH-1:0]               data_i,
  output logic                                       done_o,
  output logic signed [DATA_WIDTH+COEF_WIDTH-COEF_FRAC-1:0] term_o
);

  localparam int PW = DATA_WIDTH + COEF_WIDTH;
  localparam int CW = $clog2(COEF_WIDTH);
  localparam logic [CW-1:0] LAST_BIT = CW'(COEF_WIDTH - 1);
  localparam logic signed [PW-1:0] RND_HALF = PW'(1) << (COEF_FRAC - 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [COEF_WIDTH-1:0] coef_q, coef_d;
  logic signed [PW-1:0]  mcand_q, mcand_d;
  logic signed [PW-1:0]  acc_q, acc_d;
  logic signed [PW-1:0]  addend;
  logic signed [PW-1:0]  rnd_sum;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    coef_d  = coef_q;
    mcand_d = mcand_q;
    acc_d   = acc_q;
    addend  = coef_q[0] ? mcand_q : '0;
    if (start_i) begin
      busy_d  = 1'b1;
      cnt_d   = '0;
      coef_d  = coef_i;
      mcand_d = {{COEF_WIDTH{data_i[DATA_WIDTH-1]}}, data_i};
      acc_d   = '0;
    end else if (busy_q) begin
      // sign bit of the coefficient carries negative weight
      acc_d   = (cnt_q == LAST_BIT) ? acc_q - addend : acc_q + addend;
      mcand_d = mcand_q <<< 1;
      coef_d  = coef_q >> 1;
      cnt_d   = cnt_q + CW'(1);
      if (cnt_q == LAST_BIT) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    coef_q  <= coef_d;
    mcand_q <= mcand_d;
    acc_q   <= acc_d;
  end

  // round half up, then floor by the fraction bits
  assign rnd_sum = acc_q + RND_HALF;
  assign term_o  = rnd_sum[PW-1:COEF_FRAC];
  assign done_o  = done_q;

  `BQF_ASSERT_IMPL(a_start_when_free, clk_i, rst_ni, start_i, !busy_q)
  `BQF_ASSERT_NEXT(a_last_bit_done, clk_i, rst_ni, busy_q && cnt_q == LAST_BIT && !start_i, done_o && !busy_q)

endmodule

### rtl/biquad_iir_filter_core.sv
`timescale 1ns / 1ps
`include "biquad_iir_filter_core_defines.svh"
// Channel | Direction | Handshake                | Payload
// input   | in        | in_valid_i / in_stall_o   | sample_in_i
// output  | out       | out_valid_o / out_stall_i | sample_out_o, clipped_o
// config  | in        | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// The core takes no new sample until the last one has been written to the output
// register: five products in series through one bit-serial multiplier, each over
// the 16 coefficient bits with a handoff between, and the node clamping state.
// Reset clears the delays, the control and loads the default coefficients.
// A waiting result does not block the next input beat; a finished sample holds
// in the core until the output register is free.

module biquad_iir_filter_core
  import bqf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16,
  parameter int STATE_WIDTH  = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out_o,
  output logic                           clipped_o,
  input  logic                           cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0]       cfg_idx_i,
  input  logic [COEF_WIDTH-1:0]          cfg_data_i
);

  localparam int TW   = STATE_WIDTH + COEF_WIDTH - COEF_FRAC;
  localparam int SUMW = ((SAMPLE_WIDTH > STATE_WIDTH) ? SAMPLE_WIDTH : STATE_WIDTH) + 4;
  localparam logic signed [SUMW-1:0] NODE_HI =
    {{(SUMW-STATE_WIDTH+1){1'b0}}, {(STATE_WIDTH-1){1'b1}}};
  localparam logic signed [SUMW-1:0] NODE_LO = ~NODE_HI;
  localparam logic signed [SUMW-1:0] OUT_HI =
    {{(SUMW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SUMW-1:0] OUT_LO = ~OUT_HI;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_NODE,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    STEP_A1,
    STEP_A2,
    STEP_B0,
    STEP_B1,
    STEP_B2
  } step_e;

  state_e state_q;
  step_e  step_q;

  logic signed [COEF_WIDTH-1:0]   b0_q, b1_q, b2_q, a1_q, a2_q;
  logic signed [STATE_WIDTH-1:0]  d1_q, d2_q, node_q;
  logic signed [SAMPLE_WIDTH-1:0] x_q, sample_out_q;
  logic signed [SUMW-1:0]         acc_q;
  logic                           hit_q, clipped_q, out_valid_q, mul_start_q;

  logic signed [COEF_WIDTH-1:0]   mul_coef;
  logic signed [STATE_WIDTH-1:0]  mul_data;
  logic                           mul_done;
  logic signed [TW-1:0]           mul_term;
  logic signed [SUMW-1:0]         term_ext, x_ext;
  logic signed [STATE_WIDTH-1:0]  node_sat;
  logic                           node_clip;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;
  logic                           y_clip;
  logic                           out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q <= B0_RESET;
      b1_q <= B1_RESET;
      b2_q <= B2_RESET;
      a1_q <= A1_RESET;
      a2_q <= A2_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_B0:  b0_q <= cfg_data_i;
        REG_B1:  b1_q <= cfg_data_i;
        REG_B2:  b2_q <= cfg_data_i;
        REG_A1:  a1_q <= cfg_data_i;
        REG_A2:  a2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (step_q)
      STEP_A1: begin mul_coef = a1_q; mul_data = d1_q;   end
      STEP_A2: begin mul_coef = a2_q; mul_data = d2_q;   end
      STEP_B0: begin mul_coef = b0_q; mul_data = node_q; end
      STEP_B1: begin mul_coef = b1_q; mul_data = d1_q;   end
      STEP_B2: begin mul_coef = b2_q; mul_data = d2_q;   end
      default: begin mul_coef = '0;   mul_data = '0;     end
    endcase
  end

  bqf_serial_mult #(
    .DATA_WIDTH (STATE_WIDTH)
  ) u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start_q),
    .coef_i  (mul_coef),
    .data_i  (mul_data),
    .done_o  (mul_done),
    .term_o  (mul_term)
  );

  assign term_ext = {{(SUMW-TW){mul_term[TW-1]}}, mul_term};
  assign x_ext    = {{(SUMW-SAMPLE_WIDTH){x_q[SAMPLE_WIDTH-1]}}, x_q};

  always_comb begin
    node_clip = 1'b1;
    if (acc_q > NODE_HI) begin
      node_sat = NODE_HI[STATE_WIDTH-1:0];
    end else if (acc_q < NODE_LO) begin
      node_sat = NODE_LO[STATE_WIDTH-1:0];
    end else begin
      node_sat  = acc_q[STATE_WIDTH-1:0];
      node_clip = 1'b0;
    end
    y_clip = 1'b1;
    if (acc_q > OUT_HI) begin
      y_sat = OUT_HI[SAMPLE_WIDTH-1:0];
    end else if (acc_q < OUT_LO) begin
      y_sat = OUT_LO[SAMPLE_WIDTH-1:0];
    end else begin
      y_sat  = acc_q[SAMPLE_WIDTH-1:0];
      y_clip = 1'b0;
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      step_q       <= STEP_A1;
      mul_start_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      hit_q        <= 1'b0;
      d1_q         <= '0;
      d2_q         <= '0;
      x_q          <= '0;
      acc_q        <= '0;
      node_q       <= '0;
      sample_out_q <= '0;
      clipped_q    <= 1'b0;
    end else begin
      mul_start_q <= 1'b0;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            x_q         <= sample_in_i;
            hit_q       <= 1'b0;
            step_q      <= STEP_A1;
            mul_start_q <= 1'b1;
            state_q     <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            unique case (step_q)
              STEP_A1: begin
                acc_q       <= x_ext - term_ext;
                step_q      <= STEP_A2;
                mul_start_q <= 1'b1;
              end
              STEP_A2: begin
                acc_q   <= acc_q - term_ext;
                state_q <= ST_NODE;
              end
              STEP_B0: begin
                acc_q       <= term_ext;
                step_q      <= STEP_B1;
                mul_start_q <= 1'b1;
              end
              STEP_B1: begin
                acc_q       <= acc_q + term_ext;
                step_q      <= STEP_B2;
                mul_start_q <= 1'b1;
              end
              STEP_B2: begin
                acc_q   <= acc_q + term_ext;
                state_q <= ST_DONE;
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_NODE: begin
          node_q      <= node_sat;
          hit_q       <= node_clip;
          step_q      <= STEP_B0;
          mul_start_q <= 1'b1;
          state_q     <= ST_MUL;
        end
        ST_DONE: begin
          if (out_free) begin
            sample_out_q <= y_sat;
            clipped_q    <= hit_q | y_clip;
            out_valid_q  <= 1'b1;
            d2_q         <= d1_q;
            d1_q         <= node_q;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;
  assign clipped_o    = clipped_q;

  `BQF_ASSERT_IMPL(a_done_in_mul, clk_i, rst_ni, mul_done, state_q == ST_MUL)
  `BQF_ASSERT_IMPL(a_out_from_done, clk_i, rst_ni, $rose(out_valid_q), $past(state_q == ST_DONE))
  `BQF_ASSERT_NEXT(a_beat_starts_mul, clk_i, rst_ni, in_valid_i && !in_stall_o, mul_start_q && step_q == STEP_A1)

endmodule
